@@ sv/skct_pkg.sv @@
// Shared widths, codes and bus types for the sorted key count table.
`timescale 1ns / 1ps

package skct_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_W        = 32;
  localparam int CNT_W        = 24;
  localparam int RANK_W       = 8;
  localparam int SQ_W         = 2 * CNT_W;
  localparam int ACC_W        = 64;
  localparam int NORM_W       = 56;
  localparam int OUT_POS_W    = 9;

  // Operation codes
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_READ   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              find;     // compare phase: capture position flags
    logic              ins_new;  // shift up and place a new entry
    logic              ins_add;  // overwrite the count of the matching entry
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  add;
    logic [CNT_W-1:0]  sum;
    logic [RANK_W-1:0] rank;
  } skct_bus_t;

  // Per-cell flags back to the controller
  typedef struct packed {
    logic lt;    // holds a valid key below the search key
    logic hit;   // this cell is the sorted position of the search key
    logic pick;  // this cell supplies the result entry
  } skct_flag_t;

endpackage

@@ sv/skct_cell.sv @@
// One table cell: holds a key and its count, compares and shifts with its neighbour.
`timescale 1ns / 1ps

module skct_cell import skct_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int INDEX    = 0,
  localparam int UW      = $clog2(CAPACITY + 1),
  localparam int RW      = (UW > RANK_W) ? UW : RANK_W
) (
  input  logic             clk,
  input  skct_bus_t        bus,
  input  logic [UW-1:0]    used,
  input  logic [KEY_W-1:0] nb_key,
  input  logic [CNT_W-1:0] nb_count,
  input  logic             nb_lt,
  output logic [KEY_W-1:0] key,
  output logic [CNT_W-1:0] count,
  output skct_flag_t       flag,
  output logic [KEY_W-1:0] pick_key,
  output logic [CNT_W-1:0] pick_count
);

  localparam logic [UW-1:0] IDX_U = UW'(INDEX);
  localparam logic [RW-1:0] IDX_R = RW'(INDEX);

  logic valid;
  logic lt;
  logic hit_now;
  logic pick;
  logic hit_q;
  logic ge_q;

  // Compare against the broadcast key
  assign valid   = IDX_U < used;
  assign lt      = valid && (key < bus.key);
  assign hit_now = nb_lt && !lt;

  always_comb begin
    if (bus.func == FN_READ) begin
      pick = valid && (RW'(bus.rank) == IDX_R);
    end else begin
      pick = hit_now && valid && (key == bus.key);
    end
  end

  assign flag       = '{lt: lt, hit: hit_now, pick: pick};
  assign pick_key   = key & {KEY_W{pick}};
  assign pick_count = count & {CNT_W{pick}};

  // Hold position flags for the update phase
  always_ff @(posedge clk) begin
    if (bus.find) begin
      hit_q <= hit_now;
      ge_q  <= !lt;
    end
  end

  // Place, shift up or overwrite the count
  always_ff @(posedge clk) begin
    if (bus.ins_new && ge_q) begin
      if (hit_q) begin
        key   <= bus.key;
        count <= bus.add;
      end else begin
        key   <= nb_key;
        count <= nb_count;
      end
    end else if (bus.ins_add && hit_q) begin
      count <= bus.sum;
    end
  end

endmodule

@@ sv/sorted_key_count_table.sv @@
// Top level of the sorted key count table: controller, cell row and norm update.
`timescale 1ns / 1ps

// Usage
// A request is taken on a rising edge with start high and busy low. func selects
// insert (add add_count to key, creating the key at its sorted place if absent) or
// read (key and count at rank). Each request gives exactly one result, shown on the
// result ports for one cycle with done high; the receiver cannot stall, so results
// are simply dropped if not sampled.
// Timing: the request edge is followed by a compare edge (all cells compare the key
// in parallel), an update edge (cells shift or overwrite, old count squared), a
// square edge (new count squared) and a norm edge that loads the result registers.
// done is high in the cycle after the norm edge. busy falls in the norm cycle, so a
// new request can be taken while the last one loads its results; the two 24x24
// squaring steps and the cell update keep busy high before that.
// A full table drops a new key with status full. Counts saturate at 24 bits.
// Reset (synchronous, active high) empties the table and clears the norm; stored
// keys and counts are not cleared since only occupied entries are ever read.
module sorted_key_count_table import skct_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic [KEY_W-1:0]     key,
  input  logic [CNT_W-1:0]     add_count,
  input  logic [RANK_W-1:0]    rank,
  output logic                 done,
  output logic [OUT_POS_W-1:0] position,
  output logic                 was_new,
  output logic [KEY_W-1:0]     entry_key,
  output logic [CNT_W-1:0]     entry_count,
  output logic [OUT_POS_W-1:0] used_entries,
  output logic [NORM_W-1:0]    norm_squared,
  output logic [1:0]           status
);

  localparam int UW = $clog2(CAPACITY + 1);
  localparam int PW = (UW > OUT_POS_W) ? UW : OUT_POS_W;
  localparam logic [UW-1:0] CAP_U = UW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIND = 5'b00010,
    S_UPD  = 5'b00100,
    S_SQ   = 5'b01000,
    S_NORM = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Request registers
  logic              func_q;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  add_q;
  logic [RANK_W-1:0] rank_q;

  // Compare results
  logic [PW-1:0]     pos_q;
  logic              found_q;
  logic              full_q;
  logic [KEY_W-1:0]  gkey_q;
  logic [CNT_W-1:0]  gcount_q;

  // Update results
  logic              was_new_q;
  logic [1:0]        status_q;
  logic [KEY_W-1:0]  ekey_q;
  logic [CNT_W-1:0]  ecount_q;
  logic [CNT_W-1:0]  dv_q;
  logic [SQ_W-1:0]   sq_old_q;
  logic [SQ_W-1:0]   sq_new_q;

  // Architectural state
  logic [UW-1:0]     used;
  logic [ACC_W-1:0]  norm;
  logic [ACC_W-1:0]  norm_next;
  logic [PW-1:0]     used_ext;

  // Cell row signals
  skct_bus_t         bus;
  logic [KEY_W-1:0]  cell_key   [CAPACITY];
  logic [CNT_W-1:0]  cell_count [CAPACITY];
  logic [KEY_W-1:0]  pick_key   [CAPACITY];
  logic [CNT_W-1:0]  pick_count [CAPACITY];
  skct_flag_t        flag       [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] pick_vec;

  // Gathered compare results
  logic [UW-1:0]     pos_or;
  logic              any_hit;
  logic [KEY_W-1:0]  key_or;
  logic [CNT_W-1:0]  count_or;

  // Update-phase arithmetic
  logic [CNT_W:0]    sum_wide;
  logic              sat;
  logic [CNT_W-1:0]  sum;
  logic              ins_add_c;
  logic              ins_new_c;

  logic accept;

  assign accept = start && !busy;
  assign busy   = !(state == S_IDLE || state == S_NORM);

  // Sequence the request through the cell row
  always_comb begin
    unique case (state)
      S_IDLE:  state_next = accept ? S_FIND : S_IDLE;
      S_FIND:  state_next = S_UPD;
      S_UPD:   state_next = S_SQ;
      S_SQ:    state_next = S_NORM;
      S_NORM:  state_next = accept ? S_FIND : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      key_q  <= key;
      add_q  <= add_count;
      rank_q <= rank;
    end
  end

  // Saturating count add
  assign sum_wide  = {1'b0, gcount_q} + {1'b0, add_q};
  assign sat       = sum_wide[CNT_W];
  assign sum       = sat ? {CNT_W{1'b1}} : sum_wide[CNT_W-1:0];
  assign ins_add_c = (func_q == FN_INSERT) && found_q;
  assign ins_new_c = (func_q == FN_INSERT) && !found_q && !full_q;

  // Broadcast to the cells
  always_comb begin
    bus.find    = (state == S_FIND);
    bus.ins_new = (state == S_UPD) && ins_new_c;
    bus.ins_add = (state == S_UPD) && ins_add_c;
    bus.func    = func_q;
    bus.key     = key_q;
    bus.add     = add_q;
    bus.sum     = sum;
    bus.rank    = rank_q;
  end

  // Row of cells, each fed by its lower neighbour
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_W-1:0] nb_key;
    logic [CNT_W-1:0] nb_count;
    logic             nb_lt;

    if (g == 0) begin : g_first
      assign nb_key   = '0;
      assign nb_count = '0;
      assign nb_lt    = 1'b1;
    end else begin : g_rest
      assign nb_key   = cell_key[g-1];
      assign nb_count = cell_count[g-1];
      assign nb_lt    = flag[g-1].lt;
    end

    skct_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk        (clk),
      .bus        (bus),
      .used       (used),
      .nb_key     (nb_key),
      .nb_count   (nb_count),
      .nb_lt      (nb_lt),
      .key        (cell_key[g]),
      .count      (cell_count[g]),
      .flag       (flag[g]),
      .pick_key   (pick_key[g]),
      .pick_count (pick_count[g])
    );

    assign hit_vec[g]  = flag[g].hit;
    assign pick_vec[g] = flag[g].pick;
  end

  // Encode the position and gather the picked entry
  always_comb begin
    pos_or   = '0;
    any_hit  = 1'b0;
    key_or   = '0;
    count_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_or   = pos_or | ({UW{hit_vec[i]}} & UW'(i));
      any_hit  = any_hit | hit_vec[i];
      key_or   = key_or | pick_key[i];
      count_or = count_or | pick_count[i];
    end
  end

  // Capture the compare phase
  always_ff @(posedge clk) begin
    if (state == S_FIND) begin
      if (func_q == FN_READ) begin
        pos_q <= PW'(rank_q);
      end else begin
        pos_q <= any_hit ? PW'(pos_or) : PW'(CAP_U);
      end
      found_q  <= |pick_vec;
      full_q   <= (used == CAP_U);
      gkey_q   <= key_or;
      gcount_q <= count_or;
    end
  end

  // Form the result and the old square
  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      was_new_q <= ins_new_c;
      sq_old_q  <= ins_add_c ? (gcount_q * gcount_q) : '0;
      if (func_q == FN_READ) begin
        status_q <= found_q ? ST_OK : ST_RANGE;
        ekey_q   <= gkey_q;
        ecount_q <= gcount_q;
        dv_q     <= '0;
      end else if (found_q) begin
        status_q <= sat ? ST_SAT : ST_OK;
        ekey_q   <= key_q;
        ecount_q <= sum;
        dv_q     <= sum;
      end else if (full_q) begin
        status_q <= ST_FULL;
        ekey_q   <= key_q;
        ecount_q <= '0;
        dv_q     <= '0;
      end else begin
        status_q <= ST_OK;
        ekey_q   <= key_q;
        ecount_q <= add_q;
        dv_q     <= add_q;
      end
    end
  end

  // Square the new count
  always_ff @(posedge clk) begin
    if (state == S_SQ) begin
      sq_new_q <= dv_q * dv_q;
    end
  end

  // Remove the old square, add the new one
  assign norm_next = norm - ACC_W'(sq_old_q) + ACC_W'(sq_new_q);
  assign used_ext  = PW'(used);

  // Entry count and norm
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      norm <= '0;
    end else begin
      if (bus.ins_new) begin
        used <= used + UW'(1);
      end
      if (state == S_NORM) begin
        norm <= norm_next;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_NORM);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state == S_NORM) begin
      position     <= pos_q[OUT_POS_W-1:0];
      was_new      <= was_new_q;
      entry_key    <= ekey_q;
      entry_count  <= ecount_q;
      used_entries <= used_ext[OUT_POS_W-1:0];
      status       <= status_q;
      norm_squared <= (|norm_next[ACC_W-1:NORM_W]) ? {NORM_W{1'b1}}
                                                    : norm_next[NORM_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_done_after_norm: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_NORM))
    else $error("result strobe without a finished request");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CAP_U)
    else $error("entry count above capacity");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> ($onehot0(hit_vec) && $onehot0(pick_vec)))
    else $error("more than one cell claims the position");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (used == CAP_U))
    else $error("full status with room left");
`endif

endmodule
